[sv/lms_pkg.sv]
// Shared types, codes and tables for the LED matrix scan driver.
package lms_pkg;

	localparam int FB_BYTES_DEF = 256;
	localparam int BYTE_W       = 8;
	localparam int START_W      = 7;
	localparam int COL_W        = 5;

	localparam logic [BYTE_W-1:0] DRIVE_NONE  = 8'hFF;
	localparam logic [BYTE_W-1:0] ON_TIME_RST = 8'd16;

	// Item command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		REG_START_COLUMN = 2'd0,
		REG_ON_TIME      = 2'd1,
		REG_SLOT_TIME    = 2'd2,
		REG_ROTATE       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PORT_A0 = 2'd0,
		PORT_A1 = 2'd1,
		PORT_C0 = 2'd2,
		PORT_C1 = 2'd3
	} port_t;

	// Port wiring per matrix 0..7
	localparam port_t ANODE_OF [8] = '{
		PORT_A0, PORT_A1, PORT_A0, PORT_A1, PORT_C0, PORT_C1, PORT_C0, PORT_C1
	};
	localparam port_t CATHODE_OF [8] = '{
		PORT_C0, PORT_C0, PORT_C1, PORT_C1, PORT_A0, PORT_A0, PORT_A1, PORT_A1
	};

	typedef struct packed {
		port_t             anode_port;
		logic [BYTE_W-1:0] anode_drive_n;
		port_t             cathode_port;
		logic [BYTE_W-1:0] cathode_select_n;
		logic              frame_end;
	} res_t;

	localparam res_t RES_IDLE = '{
		anode_port:       PORT_A0,
		anode_drive_n:    DRIVE_NONE,
		cathode_port:     PORT_A0,
		cathode_select_n: DRIVE_NONE,
		frame_end:        1'b0
	};

endpackage

[sv/lms_store.sv]
// Frame buffer memory: clear sweep after reset, one write port, forwarded read.
module lms_store import lms_pkg::*; #(
	parameter int FB_BYTES = FB_BYTES_DEF,
	localparam int AW = $clog2(FB_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [7:0]        wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data,
	output logic              clearing
);

	localparam int WA = ((AW >= 8) ? AW : 8) + 1;

	logic [BYTE_W-1:0] mem_q [FB_BYTES];
	logic [BYTE_W-1:0] rd_data_q;
	logic              clearing_q;
	logic [AW-1:0]     clr_addr_q;

	logic [WA-1:0]     wa_mod;
	logic              we;
	logic [AW-1:0]     wa;
	logic [BYTE_W-1:0] wd;

	// write_addr < 256 <= 4 * FB_BYTES: three conditional subtracts reduce it
	always_comb begin
		wa_mod = WA'(wr_addr);
		for (int k = 0; k < 3; k++) begin
			if (wa_mod >= WA'(FB_BYTES))
				wa_mod = wa_mod - WA'(FB_BYTES);
		end
	end

	assign we = clearing_q || wr_en;
	assign wa = clearing_q ? clr_addr_q : wa_mod[AW-1:0];
	assign wd = clearing_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(FB_BYTES - 1))
				clearing_q <= 1'b0;
			else
				clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
		rd_data_q <= (we && (wa == rd_addr)) ? wd : mem_q[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

[sv/lms_scan.sv]
// Scan sequencer: config registers, PWM phase timing, port mapping, next read address.
module lms_scan import lms_pkg::*; #(
	parameter int FB_BYTES = FB_BYTES_DEF,
	localparam int AW = $clog2(FB_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  reg_idx_t           cfg_idx,
	input  logic [BYTE_W-1:0]  cfg_wdata,
	input  logic               tick,
	input  logic [BYTE_W-1:0]  rd_data,
	output logic [AW-1:0]      rd_addr,
	output res_t               tick_res
);

	localparam int HALF_BYTES = FB_BYTES / 2;
	localparam int SW = ((AW > START_W) ? AW : START_W) + 2;

	logic [START_W-1:0] start_q;
	logic [BYTE_W-1:0]  on_q;
	logic [BYTE_W-1:0]  slot_q;
	logic               rot_q;

	logic [COL_W-1:0]   col_q;
	logic               half_q;
	logic [2:0]         bit_q;
	logic [BYTE_W-1:0]  timer_q;
	logic               phase_q;

	logic [COL_W-1:0]   col_n;
	logic               half_n;
	logic [2:0]         bit_n;
	logic [BYTE_W-1:0]  timer_n;
	logic               phase_n;
	logic               frame;

	logic               lit;
	logic [BYTE_W-1:0]  lit_off;
	logic [BYTE_W-1:0]  unlit_len;
	logic               ph;
	logic [BYTE_W-1:0]  tm;
	logic [BYTE_W-1:0]  tm_dec;

	logic [2:0]         matrix;
	logic [2:0]         offset;
	logic [2:0]         row;

	logic [START_W-1:0] start_d;
	logic [SW-1:0]      base_rem;
	logic [SW-1:0]      addr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			on_q    <= ON_TIME_RST;
			slot_q  <= '0;
			rot_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START_COLUMN: start_q <= cfg_wdata[START_W-1:0];
				REG_ON_TIME:      on_q    <= cfg_wdata;
				REG_SLOT_TIME:    slot_q  <= cfg_wdata;
				REG_ROTATE:       rot_q   <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Phase timing of the current bit
	always_comb begin
		lit       = rd_data[bit_q];
		lit_off   = (slot_q > on_q) ? (slot_q - on_q) : '0;
		unlit_len = lit ? lit_off : slot_q;
		if (timer_q == '0) begin
			if (lit && (on_q != '0)) begin
				ph = 1'b1;
				tm = on_q;
			end else begin
				ph = 1'b0;
				// zero-length bit still takes one idle tick
				tm = (unlit_len != '0) ? unlit_len : BYTE_W'(1);
			end
		end else begin
			ph = phase_q;
			tm = timer_q;
		end
		tm_dec = tm - BYTE_W'(1);

		col_n   = col_q;
		half_n  = half_q;
		bit_n   = bit_q;
		timer_n = timer_q;
		phase_n = phase_q;
		frame   = 1'b0;
		if (tick) begin
			phase_n = ph;
			timer_n = tm_dec;
			if (tm_dec == '0) begin
				if (ph && (lit_off != '0)) begin
					phase_n = 1'b0;
					timer_n = lit_off;
				end else begin
					phase_n = 1'b0;
					timer_n = '0;
					bit_n   = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						half_n = ~half_q;
						if (half_q) begin
							col_n = col_q + COL_W'(1);
							frame = (col_q == '1);
						end
					end
				end
			end
		end
	end

	// Matrix / port mapping
	always_comb begin
		matrix = rot_q ? ~{col_q[4:3], half_q} : {col_q[4:3], half_q};
		offset = rot_q ? ~col_q[2:0] : col_q[2:0];
		row    = rot_q ? ~bit_q : bit_q;
		tick_res.anode_port       = ANODE_OF[matrix];
		tick_res.anode_drive_n    = ph ? ~(BYTE_W'(1) << row) : DRIVE_NONE;
		tick_res.cathode_port     = CATHODE_OF[matrix];
		tick_res.cathode_select_n = ~(BYTE_W'(1) << offset);
		tick_res.frame_end        = frame;
	end

	// Address of the byte needed next cycle, with a start_column write folded in
	always_comb begin
		start_d = (cfg_we && (cfg_idx == REG_START_COLUMN)) ?
			cfg_wdata[START_W-1:0] : start_q;
		base_rem = SW'(start_d);
		for (int k = 0; k < 3; k++) begin
			if (base_rem >= SW'(HALF_BYTES))
				base_rem = base_rem - SW'(HALF_BYTES);
		end
		addr_sum = (base_rem << 1) + SW'({col_n, half_n});
		if (addr_sum >= SW'(FB_BYTES))
			addr_sum = addr_sum - SW'(FB_BYTES);
		rd_addr = addr_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			half_q  <= 1'b0;
			bit_q   <= '0;
			timer_q <= '0;
			phase_q <= 1'b0;
		end else begin
			col_q   <= col_n;
			half_q  <= half_n;
			bit_q   <= bit_n;
			timer_q <= timer_n;
			phase_q <= phase_n;
		end
	end

endmodule

[sv/lms_outbuf.sv]
// Two-deep result buffer: output register plus skid register.
module lms_outbuf import lms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	input  logic stall,
	output logic valid,
	output res_t res,
	output logic full
);

	res_t main_q;
	res_t skid_q;
	logic main_v_q;
	logic skid_v_q;
	logic take;

	assign take = main_v_q && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || take) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || take) begin
			main_q <= skid_v_q ? skid_q : push_res;
			if (skid_v_q && push)
				skid_q <= push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign valid = main_v_q;
	assign res   = main_q;
	assign full  = skid_v_q;

endmodule

[sv/led_matrix_scan_pwm.sv]
// Top level of the multiplexed LED matrix scan driver with PWM timing.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  item    | in        | item_valid / item_stall    | cmd, write_addr, write_data
//  result  | out       | res_valid / res_stall      | anode_port, anode_drive_n,
//          |           |                            | cathode_port, cathode_select_n,
//          |           |                            | frame_end
//  config  | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per clock while item_stall is low. A scan tick is evaluated in the
// cycle it is accepted and its result is registered at that edge; the frame
// buffer read port is aimed each cycle at the byte the following tick will need.
// After reset a clearing pass zeroes the frame buffer with item_stall held high;
// config writes are taken throughout. The result side is two deep, so outside
// the clearing pass item_stall only rises when both the output and the skid
// register hold results.
module led_matrix_scan_pwm import lms_pkg::*; #(
	parameter int FB_BYTES = FB_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              item_valid,
	output logic              item_stall,
	input  logic              cmd,
	input  logic [7:0]        write_addr,
	input  logic [BYTE_W-1:0] write_data,

	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        anode_port,
	output logic [BYTE_W-1:0] anode_drive_n,
	output logic [1:0]        cathode_port,
	output logic [BYTE_W-1:0] cathode_select_n,
	output logic              frame_end,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data
);

	localparam int AW = $clog2(FB_BYTES);

	logic              accept;
	logic              tick;
	logic              wr_en;
	logic              clearing;
	logic              buf_full;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	res_t              tick_res;
	res_t              push_res;
	res_t              out_res;

	// Config registers always take a transaction
	assign cfg_ready = 1'b1;

	assign item_stall = buf_full || clearing;
	assign accept     = item_valid && !item_stall;
	assign tick       = accept && (cmd == CMD_TICK);
	assign wr_en      = accept && (cmd == CMD_WRITE);

	lms_store #(.FB_BYTES(FB_BYTES)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (write_addr),
		.wr_data  (write_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	lms_scan #(.FB_BYTES(FB_BYTES)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (reg_idx_t'(cfg_index)),
		.cfg_wdata (cfg_data),
		.tick      (tick),
		.rd_data   (rd_data),
		.rd_addr   (rd_addr),
		.tick_res  (tick_res)
	);

	// A buffer write returns the all-off drive
	assign push_res = (cmd == CMD_WRITE) ? RES_IDLE : tick_res;

	lms_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_res (push_res),
		.stall    (res_stall),
		.valid    (res_valid),
		.res      (out_res),
		.full     (buf_full)
	);

	assign anode_port       = out_res.anode_port;
	assign anode_drive_n    = out_res.anode_drive_n;
	assign cathode_port     = out_res.cathode_port;
	assign cathode_select_n = out_res.cathode_select_n;
	assign frame_end        = out_res.frame_end;

endmodule

[sv/lms_checker.sv]
// Port-level checks for the LED matrix scan driver, bound to the top level.
module lms_checker import lms_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] anode_port,
	input logic [7:0] anode_drive_n,
	input logic [1:0] cathode_port,
	input logic [7:0] cathode_select_n,
	input logic       frame_end
);

	// Held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(anode_drive_n)
			&& $stable(cathode_select_n) && $stable(frame_end))
		else $error("result changed while stalled");

	// Either exactly one column selected, or the all-off write transaction
	a_one_column: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($countones(~cathode_select_n) == 1) ||
			(cathode_select_n == DRIVE_NONE && anode_drive_n == DRIVE_NONE &&
			 anode_port == PORT_A0 && cathode_port == PORT_A0 && !frame_end))
		else $error("bad column select");

	// At most one anode line driven
	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && anode_drive_n != DRIVE_NONE |-> $countones(~anode_drive_n) == 1)
		else $error("more than one anode driven");

	// Anodes and cathodes sit on opposite port banks
	a_port_banks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && cathode_select_n != DRIVE_NONE |-> anode_port[1] != cathode_port[1])
		else $error("anode and cathode on the same bank");

	// Frame end only on the last panel column, which is an edge column of a matrix
	a_frame_col: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> cathode_select_n == 8'h7F || cathode_select_n == 8'hFE)
		else $error("frame end on a middle column");

endmodule

bind led_matrix_scan_pwm lms_checker u_lms_checker (.*);

[verif/tb_led_matrix_scan_pwm.sv]
// Self-checking testbench for the LED matrix scan driver, predicting each port drive.
`timescale 1ns / 1ps

module tb_led_matrix_scan_pwm import lms_pkg::*; ();

	// Tracks the scan state and the registers, keeps the expected port drive
	// of every accepted item in order and checks results against it.
	class scan_scoreboard;
		logic [7:0] pixel_mem [256];
		logic [4:0] col;
		logic       half;
		logic [2:0] bit_idx;
		logic [7:0] ticks_left;
		logic       drive_on;
		logic [6:0] start_col;
		logic [7:0] on_ticks;
		logic [7:0] slot_ticks;
		logic       mirror;
		res_t       drive_q [$];
		int         mismatches;

		function new();
			foreach (pixel_mem[i])
				pixel_mem[i] = '0;
			col        = '0;
			half       = 1'b0;
			bit_idx    = '0;
			ticks_left = '0;
			drive_on   = 1'b0;
			start_col  = '0;
			on_ticks   = ON_TIME_RST;
			slot_ticks = '0;
			mirror     = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] val);
			case (idx)
				REG_START_COLUMN: start_col = val[6:0];
				REG_ON_TIME:      on_ticks = val;
				REG_SLOT_TIME:    slot_ticks = val;
				REG_ROTATE:       mirror = val[0];
				default:          ;
			endcase
		endfunction

		function logic [7:0] lit_off_ticks();
			return (slot_ticks > on_ticks) ? slot_ticks - on_ticks : 8'd0;
		endfunction

		// step to the next row bit; 1 when a whole frame wraps
		function logic next_bit();
			drive_on   = 1'b0;
			ticks_left = '0;
			bit_idx    = bit_idx + 3'd1;
			if (bit_idx != 3'd0)
				return 1'b0;
			half = ~half;
			if (half)
				return 1'b0;
			col = col + 5'd1;
			return col == 5'd0;
		endfunction

		function res_t scan_tick();
			logic [7:0] addr;
			logic [7:0] off_len;
			logic       lit;
			logic [2:0] matrix;
			logic [2:0] offset;
			logic [2:0] row;
			res_t       r;
			addr = {start_col, 1'b0} + {2'b00, col, 1'b0} + {7'd0, half};
			lit  = pixel_mem[addr][bit_idx];
			if (ticks_left == 8'd0) begin
				off_len = lit ? lit_off_ticks() : slot_ticks;
				if (lit && on_ticks != 8'd0) begin
					drive_on   = 1'b1;
					ticks_left = on_ticks;
				end else begin
					// zero-length bit still burns one dark tick
					drive_on   = 1'b0;
					ticks_left = (off_len != 8'd0) ? off_len : 8'd1;
				end
			end
			matrix = {col[4:3], half};
			offset = col[2:0];
			row    = bit_idx;
			if (mirror) begin
				matrix = 3'd7 - matrix;
				offset = 3'd7 - offset;
				row    = 3'd7 - row;
			end
			// matrices 0..3 have anodes on A ports, matrices 4..7 on C ports
			r.anode_port = matrix[2] ? (matrix[0] ? PORT_C1 : PORT_C0)
			                         : (matrix[0] ? PORT_A1 : PORT_A0);
			r.cathode_port = matrix[2] ? (matrix[1] ? PORT_A1 : PORT_A0)
			                           : (matrix[1] ? PORT_C1 : PORT_C0);
			r.anode_drive_n    = drive_on ? ~(8'd1 << row) : DRIVE_NONE;
			r.cathode_select_n = ~(8'd1 << offset);
			r.frame_end        = 1'b0;
			ticks_left = ticks_left - 8'd1;
			if (ticks_left == 8'd0) begin
				off_len = lit_off_ticks();
				if (drive_on && off_len != 8'd0) begin
					drive_on   = 1'b0;
					ticks_left = off_len;
				end else begin
					r.frame_end = next_bit();
				end
			end
			return r;
		endfunction

		function void note_item(logic c, logic [7:0] addr, logic [7:0] data);
			res_t r;
			if (c == CMD_WRITE) begin
				pixel_mem[addr]    = data;
				r.anode_port       = PORT_A0;
				r.anode_drive_n    = DRIVE_NONE;
				r.cathode_port     = PORT_A0;
				r.cathode_select_n = DRIVE_NONE;
				r.frame_end        = 1'b0;
			end else begin
				r = scan_tick();
			end
			drive_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result ap=%0d ad=%h cp=%0d cs=%h fe=%0b",
						$realtime, got.anode_port, got.anode_drive_n, got.cathode_port,
						got.cathode_select_n, got.frame_end);
				return;
			end
			want = drive_q.pop_front();
			if (got.anode_port !== want.anode_port ||
			    got.anode_drive_n !== want.anode_drive_n ||
			    got.cathode_port !== want.cathode_port ||
			    got.cathode_select_n !== want.cathode_select_n ||
			    got.frame_end !== want.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp %0d/%h/%0d/%h/%0b got %0d/%h/%0d/%h/%0b",
						$realtime, want.anode_port, want.anode_drive_n, want.cathode_port,
						want.cathode_select_n, want.frame_end, got.anode_port,
						got.anode_drive_n, got.cathode_port, got.cathode_select_n,
						got.frame_end);
			end
		endfunction

		function int pending();
			return drive_q.size();
		endfunction
	endclass

	// Clock, reset and every block input start at known values
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       item_valid = 1'b0;
	logic       cmd        = CMD_TICK;
	logic [7:0] write_addr = '0;
	logic [7:0] write_data = '0;
	logic       res_stall  = 1'b0;
	logic       cfg_valid  = 1'b0;
	logic [1:0] cfg_index  = REG_START_COLUMN;
	logic [7:0] cfg_data   = '0;

	logic       item_stall;
	logic       res_valid;
	logic [1:0] anode_port;
	logic [7:0] anode_drive_n;
	logic [1:0] cathode_port;
	logic [7:0] cathode_select_n;
	logic       frame_end;
	logic       cfg_ready;

	// Burst flags: when set, that side stops idling for a while
	bit src_burst = 1'b0;
	bit snk_burst = 1'b0;

	scan_scoreboard sb = new();

	led_matrix_scan_pwm i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.cmd              (cmd),
		.write_addr       (write_addr),
		.write_data       (write_data),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.anode_port       (anode_port),
		.anode_drive_n    (anode_drive_n),
		.cathode_port     (cathode_port),
		.cathode_select_n (cathode_select_n),
		.frame_end        (frame_end),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one item after a random gap and hold it until the block takes it.
	// Valid is only lowered when a gap follows, so back-to-back items keep it high.
	task automatic send_item(logic c, logic [7:0] addr, logic [7:0] data);
		int gap;
		if ($urandom_range(0, 63) == 0)
			src_burst = !src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		write_addr <= addr;
		write_data <= data;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item(c, addr, data);
	endtask

	// One register write transaction; valid stays up for a following write
	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs(logic [6:0] start, logic [7:0] on_t, logic [7:0] slot_t,
	                            logic rot);
		write_reg(REG_START_COLUMN, {1'b0, start});
		write_reg(REG_ON_TIME, on_t);
		write_reg(REG_SLOT_TIME, slot_t);
		write_reg(REG_ROTATE, {7'd0, rot});
		cfg_valid <= 1'b0;
	endtask

	// Stop offering items and let every outstanding result drain out
	task automatic drain_results();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Result monitor: a transaction completes on valid with no stall
	always @(posedge clk) begin : result_watch
		res_t got;
		if (arst_n && res_valid === 1'b1 && !res_stall) begin
			got.anode_port       = port_t'(anode_port);
			got.anode_drive_n    = anode_drive_n;
			got.cathode_port     = port_t'(cathode_port);
			got.cathode_select_n = cathode_select_n;
			got.frame_end        = frame_end;
			sb.check_result(got);
		end
	end

	// Result sink: random stall per result, plus two long hold-offs so the
	// two-deep output fills and back-pressure reaches the item side.
	initial begin : result_sink
		int hold;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 200 || taken == 900) begin
				hold = 300;
			end else begin
				if ($urandom_range(0, 63) == 0)
					snk_burst = !snk_burst;
				hold = snk_burst ? 0 : $urandom_range(0, 14);
			end
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (res_valid !== 1'b1) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-tick lit bits, then unlit bits with no slot (one dark tick
		// each). Column 0 upper is all lit, lower all dark; the top ring bytes
		// are set for the wrap check below.
		program_regs(7'd0, 8'd1, 8'd0, 1'b0);
		send_item(CMD_WRITE, 8'd0, 8'hFF);
		send_item(CMD_WRITE, 8'd1, 8'h00);
		send_item(CMD_WRITE, 8'd2, 8'h81);
		send_item(CMD_WRITE, 8'd255, 8'h80);
		send_item(CMD_WRITE, 8'd254, 8'h01);
		for (int i = 0; i < 16; i++)
			send_item(CMD_TICK, 8'hFF, 8'hFF);
		drain_results();

		// Directed: window at the last ring column so reads wrap, rotate on,
		// zero brightness so lit bits only sit out their slot.
		program_regs(7'd127, 8'd0, 8'd2, 1'b1);
		for (int i = 0; i < 4; i++)
			send_item(CMD_TICK, 8'h00, 8'h00);

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			case (ph)
				0: program_regs(7'($urandom_range(0, 127)), 8'd255, 8'd255, 1'b0);
				1: program_regs(7'd0, 8'd0, 8'd0, 1'b1);
				default: begin
					if ($urandom_range(0, 7) < 5)
						// fast bits so the scan runs through whole frames
						program_regs(7'($urandom_range(0, 127)), 8'($urandom_range(0, 1)),
							8'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					else
						program_regs(7'($urandom_range(0, 127)), 8'($urandom_range(0, 6)),
							8'($urandom_range(0, 9)), 1'($urandom_range(0, 1)));
				end
			endcase
			for (int n = 0; n < 200; n++) begin
				if ($urandom_range(0, 99) < 15)
					send_item(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				else
					// address and data are don't-care on a tick; keep them moving
					send_item(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit: far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
